// ===== src/slab_size_class_allocator_defines.svh =====
// assertion macros for the slab allocator
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SLAB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SLAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slab_pkg.sv =====
`timescale 1ns / 1ps
package slab_pkg;

  localparam int unsigned AddrW = 18;
  localparam int unsigned SizeW = 12;
  localparam int unsigned StatW = 3;
  localparam int unsigned ClsW  = 3;
  localparam int unsigned SlotW = 8;
  localparam int unsigned HdrBytes = 32;
  localparam logic [SlotW-1:0] LinkEnd = 8'd255;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FREE_REJ  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_FILL,
    S_POP_RD,
    S_POP_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  // slots per page for a class: (4096 - 32) >> (4 + cls)
  function automatic logic [SlotW:0] class_slots(input logic [ClsW-1:0] c);
    logic [12:0] v;
    v = 13'(4064) >> (13'(c) + 13'd4);
    return v[SlotW:0];
  endfunction

endpackage

// ===== src/slab_ram.sv =====
`timescale 1ns / 1ps
module slab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/slab_size_class_allocator.sv =====
`timescale 1ns / 1ps
// channel   | signals                                  | dir | handshake
// ----------+------------------------------------------+-----+---------------------
// request   | start, busy, func, request_size,         | in  | start && !busy
//           | free_address                             |     |
// result    | done, slot_address, status               | out | done, one cycle
// config    | cfg_valid, cfg_ready, cfg_data           | in  | cfg_valid && cfg_ready
//
// one transaction at a time; a free reads and checks the page header, a rejected
// request goes straight to done; an allocate walks the class chain checking each
// page header, builds a fresh page's free list one link per slot (up to 254) if
// no chain page has a free slot, and reports exhaustion when the pool is out
// rst is synchronous; class heads, in-use bits and fresh page counter clear at
// once, the slot link memory needs no clearing; the result cannot be stalled
`include "slab_size_class_allocator_defines.svh"
module slab_size_class_allocator
  import slab_pkg::*;
#(
  parameter int unsigned POOL_PAGES  = 64,
  parameter int unsigned CLASS_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [SizeW-1:0]  request_size,
  input  logic [AddrW-1:0]  free_address,
  output logic              done,
  output logic [AddrW-1:0]  slot_address,
  output logic [StatW-1:0]  status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  localparam int unsigned PW  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned PNW = $clog2(POOL_PAGES + 1);
  localparam int unsigned HW  = 1 + ClsW + SlotW + (SlotW + 1) + PNW;
  localparam int unsigned LW  = PW + SlotW;
  localparam logic [PNW-1:0] Nil = PNW'(POOL_PAGES);
  localparam logic [SizeW:0] MaxSize = (SizeW + 1)'(16 << (CLASS_COUNT - 1));

  typedef struct packed {
    logic [ClsW-1:0]  cls;
    logic [SlotW-1:0] head;
    logic [SlotW:0]   count;
    logic [PNW-1:0]   next;
  } hdr_t;

  state_t state, state_next;

  logic [6:0]            usable_pages;
  logic [PNW-1:0]        class_head [CLASS_COUNT];
  logic [POOL_PAGES-1:0] in_use;
  logic [PNW-1:0]        next_fresh;

  logic [ClsW-1:0]  cls;
  logic [PNW-1:0]   page;
  logic [PW:0]      steps;
  logic [SlotW-1:0] fill_i;
  logic [SlotW-1:0] slot_idx;
  logic [11:0]      offset;
  hdr_t             hdr;
  logic [AddrW-1:0] res_addr;
  status_t          res_stat;

  // header memory (in-use bit kept in flops)
  logic          h_we;
  logic [PW-1:0] h_waddr, h_raddr;
  hdr_t          h_wdata, h_rdata;
  logic [HW-2:0] h_rraw;

  slab_ram #(.WIDTH(HW - 1), .DEPTH(POOL_PAGES)) u_hdr_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rraw)
  );
  assign h_rdata = h_rraw;

  // slot link memory
  logic             l_we;
  logic [LW-1:0]    l_waddr, l_raddr;
  logic [SlotW-1:0] l_wdata, l_rdata;

  slab_ram #(.WIDTH(SlotW), .DEPTH(POOL_PAGES * 256)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // request decode
  logic [ClsW-1:0] req_cls;
  logic            req_big;
  always_comb begin
    req_cls = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if ({1'b0, request_size} <= (SizeW + 1)'(16 << c)) begin
        req_cls = ClsW'(c);
      end
    end
    req_big = ({1'b0, request_size} > MaxSize);
  end

  logic [PNW-1:0] limit;
  assign limit = (PNW'(usable_pages) < Nil && usable_pages < 7'(POOL_PAGES)) ?
                 PNW'(usable_pages) : Nil;

  logic [SlotW:0] n_slots;
  assign n_slots = class_slots(cls);

  logic [PW-1:0] page_ix;
  assign page_ix = page[PW-1:0];

  // free address decode
  logic [AddrW-12-1:0] f_page_hi;
  assign f_page_hi = free_address[AddrW-1:12];

  // slot index from offset for the page's class
  logic [11:0] f_rel;
  assign f_rel = offset - 12'(HdrBytes);
  logic [11:0] f_idx;
  assign f_idx = f_rel >> (12'(h_rdata.cls) + 12'd4);

  logic [AddrW-1:0] alloc_addr;
  assign alloc_addr = AddrW'({page_ix, 12'd0}) + AddrW'(HdrBytes)
                      + (AddrW'(slot_idx) << (AddrW'(cls) + AddrW'(4)));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // next state and memory control
  always_comb begin
    state_next = state;
    h_we = 1'b0; h_waddr = page_ix; h_wdata = hdr; h_raddr = page_ix;
    l_we = 1'b0; l_waddr = {page_ix, fill_i}; l_wdata = '0;
    l_raddr = {page_ix, hdr.head};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func) begin
            state_next = S_FREE_RD;
          end else if (request_size == '0 || req_big) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        if (page >= Nil || steps >= (PW + 1)'(POOL_PAGES)) begin
          state_next = S_DONE;
          if (next_fresh < limit) begin
            state_next = S_FILL;
          end
        end else begin
          state_next = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (h_rdata.count != '0 && {1'b0, h_rdata.head} < n_slots) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_FILL: begin
        l_we = 1'b1;
        l_wdata = ({1'b0, fill_i} + 1'b1 < n_slots) ? fill_i + 1'b1 : LinkEnd;
        if ({1'b0, fill_i} + 1'b1 >= n_slots) begin
          h_we = 1'b1;
          h_wdata = '{cls: cls, head: '0, count: n_slots, next: class_head[cls]};
          state_next = S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        h_we = 1'b1;
        h_wdata = hdr;
        h_wdata.head = l_rdata;
        h_wdata.count = hdr.count - 1'b1;
        state_next = S_DONE;
      end
      S_FREE_RD: begin
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        state_next = S_DONE;
        if (f_idx < 12'(class_slots(h_rdata.cls)) &&
            h_rdata.count < class_slots(h_rdata.cls) && res_stat == ST_OK) begin
          h_we = 1'b1;
          h_wdata = h_rdata;
          h_wdata.head = f_idx[SlotW-1:0];
          h_wdata.count = h_rdata.count + 1'b1;
          l_we = 1'b1;
          l_waddr = {page_ix, f_idx[SlotW-1:0]};
          l_wdata = h_rdata.head;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state: config, class heads, in-use bits, fresh page counter
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= 7'd64;
      for (int c = 0; c < CLASS_COUNT; c++) class_head[c] <= Nil;
      in_use <= '0;
      next_fresh <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        usable_pages <= cfg_data;
      end
      if (state == S_WALK_RD && state_next == S_FILL) begin
        next_fresh <= next_fresh + 1'b1;
        in_use[next_fresh[PW-1:0]] <= 1'b1;
      end
      if (state == S_FILL && state_next == S_POP_RD) begin
        class_head[cls] <= page;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cls <= req_cls;
        steps <= '0;
        offset <= free_address[11:0];
        res_addr <= '0;
        if (func) begin
          page <= PNW'(free_address[AddrW-1:12]);
          if (32'(f_page_hi) >= 32'(POOL_PAGES) ||
              !in_use[free_address[12+PW-1:12]] || free_address[11:0] < 12'(HdrBytes)) begin
            res_stat <= ST_FREE_REJ;
          end else begin
            res_stat <= ST_OK;
          end
        end else begin
          page <= class_head[req_cls];
          if (request_size == '0) begin
            res_stat <= ST_ZERO;
          end else if (req_big) begin
            res_stat <= ST_TOO_LARGE;
          end else begin
            res_stat <= ST_OK;
          end
        end
      end
      S_WALK_RD: begin
        if (page >= Nil || steps >= (PW + 1)'(POOL_PAGES)) begin
          page <= next_fresh;
          fill_i <= '0;
          if (next_fresh >= limit) res_stat <= ST_EXHAUSTED;
        end
        steps <= steps + 1'b1;
      end
      S_WALK_CHK: begin
        hdr <= h_rdata;
        if (!(h_rdata.count != '0 && {1'b0, h_rdata.head} < n_slots)) begin
          page <= h_rdata.next;
        end
      end
      S_FILL: begin
        fill_i <= fill_i + 1'b1;
        hdr <= '{cls: cls, head: '0, count: n_slots, next: class_head[cls]};
      end
      S_POP_RD: begin
        slot_idx <= hdr.head;
      end
      S_POP_WR: begin
        res_addr <= alloc_addr;
      end
      S_FREE_CHK: begin
        if (!(f_idx < 12'(class_slots(h_rdata.cls)) &&
              h_rdata.count < class_slots(h_rdata.cls))) begin
          res_stat <= ST_FREE_REJ;
        end
      end
      S_DONE: begin
        slot_address <= res_addr;
        status <= res_stat;
      end
      default: begin
      end
    endcase
  end

  `SLAB_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held two cycles")
  `SLAB_ASSERT_IMP(a_fail_zero_addr, clk, rst, done && status != ST_OK,
                   slot_address == '0, "failed result carries an address")
  `SLAB_ASSERT_IMP(a_fresh_bound, clk, rst, 1'b1, next_fresh <= Nil,
                   "fresh page counter past pool")
  `SLAB_ASSERT_NEXT(a_done_after, clk, rst, state == S_DONE, done,
                    "result not strobed")
endmodule
